FILE: design/tlb_entry_store_and_probe_macros.svh
// Assertion macros shared by the translation-table checker.
`ifndef TLB_ENTRY_STORE_AND_PROBE_MACROS_SVH
`define TLB_ENTRY_STORE_AND_PROBE_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TESP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tesp assertion failed");

// Clocked assertion that is also checked during reset.
`define TESP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tesp assertion failed");

`endif

FILE: design/tesp_pkg.sv
// Types, constants and a helper function of the translation-table block.
package tesp_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned IDX_W  = 6;

    localparam logic [WORD_W-1:0] MASK_CLEAR_BITS = 32'h1fffe000;
    localparam logic [WORD_W-1:0] LOW_PAGE_BITS   = 32'h00001fff;
    localparam int unsigned       ASID_W          = 8;

    typedef enum logic [1:0] {
        MODE_READ       = 2'd0,
        MODE_WRITE_IDX  = 2'd1,
        MODE_WRITE_RAND = 2'd2,
        MODE_PROBE      = 2'd3
    } t_mode;

    typedef struct packed {
        logic [WORD_W-1:0] page_mask;
        logic [WORD_W-1:0] entry_hi;
        logic [WORD_W-1:0] entry_lo0;
        logic [WORD_W-1:0] entry_lo1;
    } t_entry;

    // Builds the stored form of an entry from the register values.
    function automatic t_entry make_entry(input logic [WORD_W-1:0] pm,
                                          input logic [WORD_W-1:0] hi,
                                          input logic [WORD_W-1:0] lo0,
                                          input logic [WORD_W-1:0] lo1);
        t_entry e;
        logic   g;
        g = lo0[0] & lo1[0];
        e.page_mask = pm;
        e.entry_hi  = hi & ~(pm & MASK_CLEAR_BITS);
        e.entry_lo0 = {lo0[WORD_W-1:1], g};
        e.entry_lo1 = {lo1[WORD_W-1:1], g};
        return e;
    endfunction

endpackage

FILE: design/tesp_cell.sv
// One storage cell of the rotating entry ring.
module tesp_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  tesp_pkg::t_entry i_entry,
    output tesp_pkg::t_entry o_entry
);

    tesp_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

FILE: design/tesp_match.sv
// Virtual page and ASID compare of one entry against the probe key.
module tesp_match (
    input  tesp_pkg::t_entry                 i_entry,
    input  logic [tesp_pkg::WORD_W-1:0]      i_key,
    output logic                             o_match
);

    logic [tesp_pkg::WORD_W-1:0] w_vmask;
    logic                        w_page_eq;
    logic                        w_global;
    logic                        w_asid_eq;

    always_comb begin
        w_vmask   = ~(i_entry.page_mask | tesp_pkg::LOW_PAGE_BITS);
        w_page_eq = ((i_key ^ i_entry.entry_hi) & w_vmask) == '0;
        w_global  = i_entry.entry_lo0[0] & i_entry.entry_lo1[0];
        w_asid_eq = i_key[tesp_pkg::ASID_W-1:0] == i_entry.entry_hi[tesp_pkg::ASID_W-1:0];
        o_match   = w_page_eq & (w_global | w_asid_eq);
    end

endmodule

FILE: design/tlb_entry_store_and_probe.sv
// Top level of the software-managed translation table with read, write and probe.
//
// Usage: requests arrive on the s_axis channel; each one selects read entry,
// write at index, write at random index or probe. Every request produces
// exactly one result on the m_axis channel (all zero for writes).
// The entries live in a ring of ENTRIES cells that rotates by one cell per
// cycle while a request seeks its entry or probes; only the cell at the head
// of the ring is read, written or compared.
// A read or write rotates the ring until the addressed entry sits at the
// head, so its time depends on how far that entry sits from the head of
// the ring. A probe walks the whole ring through the single compare unit.
// An index at or beyond ENTRIES skips the ring and goes straight to done.
// One request is worked on at a time; s_axis_tready is high only while the
// block is free. The result register holds a finished result while the
// receiver stalls, and a following request is taken meanwhile; its result
// waits until the register is free.
// Reset is synchronous and active low; it clears every entry to zero at once.
module tlb_entry_store_and_probe #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[1:0], index_reg[7:2], random_reg[13:8], page_mask[45:14],
    // entry_hi[77:46], entry_lo0[109:78], entry_lo1[141:110], zero fill
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // read_page_mask[31:0], read_entry_hi[63:32], read_entry_lo0[95:64],
    // read_entry_lo1[127:96], probe_miss[128], probe_index[134:129], zero fill
    output logic [135:0] m_axis_tdata
);

    localparam int unsigned POS_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned W     = tesp_pkg::WORD_W;
    localparam int unsigned IW    = tesp_pkg::IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEEK,
        S_PROBE,
        S_DONE
    } t_state;

    t_state                r_state;
    tesp_pkg::t_mode       r_mode;
    logic [POS_W-1:0]      r_target;
    logic [POS_W-1:0]      r_pos;
    logic [POS_W-1:0]      r_cnt;
    tesp_pkg::t_entry      r_new;
    logic [W-1:0]          r_key;
    tesp_pkg::t_entry      r_res;
    logic                  r_hit;
    logic [IW-1:0]         r_found;
    logic                  r_out_valid;
    logic [135:0]          r_out;

    tesp_pkg::t_entry      w_cell [ENTRIES];
    tesp_pkg::t_entry      w_tail;
    logic                  w_shift;
    logic                  w_insert;
    logic                  w_match;
    logic                  w_accept;
    logic                  w_out_free;
    logic [POS_W-1:0]      w_pos_next;
    tesp_pkg::t_mode       w_in_mode;
    logic [IW-1:0]         w_in_target;
    logic [IW-1:0]         w_pos_ext;

    assign w_in_mode   = tesp_pkg::t_mode'(s_axis_tdata[1:0]);
    assign w_in_target = (w_in_mode == tesp_pkg::MODE_WRITE_RAND) ?
                         s_axis_tdata[13:8] : s_axis_tdata[7:2];
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_pos_next  = (r_pos == POS_W'(ENTRIES - 1)) ? '0 : r_pos + 1'b1;
    assign w_pos_ext   = IW'(r_pos);

    always_comb begin
        w_shift  = 1'b0;
        w_insert = 1'b0;
        case (r_state)
            S_SEEK: begin
                if (r_pos == r_target) begin
                    if (r_mode != tesp_pkg::MODE_READ) begin
                        w_shift  = 1'b1;
                        w_insert = 1'b1;
                    end
                end else begin
                    w_shift = 1'b1;
                end
            end
            S_PROBE: w_shift = 1'b1;
            default: w_shift = 1'b0;
        endcase
    end

    assign w_tail = w_insert ? r_new : w_cell[0];

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        tesp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_entry ((k == ENTRIES - 1) ? w_tail : w_cell[(k + 1) % ENTRIES]),
            .o_entry (w_cell[k])
        );
    end

    tesp_match u_match (
        .i_entry (w_cell[0]),
        .i_key   (r_key),
        .o_match (w_match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_shift) begin
                r_pos <= w_pos_next;
            end
            r_out_valid <= (r_out_valid && !m_axis_tready) ||
                           ((r_state == S_DONE) && w_out_free);
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode   <= w_in_mode;
                        r_target <= POS_W'(w_in_target);
                        r_new    <= tesp_pkg::make_entry(s_axis_tdata[45:14],
                                        s_axis_tdata[77:46], s_axis_tdata[109:78],
                                        s_axis_tdata[141:110]);
                        r_key    <= s_axis_tdata[77:46];
                        r_res    <= '0;
                        r_hit    <= 1'b0;
                        r_found  <= '0;
                        r_cnt    <= '0;
                        if (w_in_mode == tesp_pkg::MODE_PROBE) begin
                            r_state <= S_PROBE;
                        end else if ({1'b0, w_in_target} >= (IW + 1)'(ENTRIES)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SEEK;
                        end
                    end
                end
                S_SEEK: begin
                    if (r_pos == r_target) begin
                        if (r_mode == tesp_pkg::MODE_READ) begin
                            r_res <= w_cell[0];
                        end
                        r_state <= S_DONE;
                    end
                end
                S_PROBE: begin
                    if (w_match && (!r_hit || w_pos_ext > r_found)) begin
                        r_hit   <= 1'b1;
                        r_found <= w_pos_ext;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == POS_W'(ENTRIES - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out <= {1'b0, r_found,
                                  (r_mode == tesp_pkg::MODE_PROBE) && !r_hit,
                                  r_res.entry_lo1, r_res.entry_lo0,
                                  r_res.entry_hi, r_res.page_mask};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

FILE: design/tesp_checker.sv
// Port-level checker of the translation-table block and its bind.
`include "tlb_entry_store_and_probe_macros.svh"

module tesp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata
);

    logic w_accept;
    logic w_stall;
    logic w_miss;
    logic w_miss_clean;

    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign w_stall      = m_axis_tvalid && !m_axis_tready;
    assign w_miss       = m_axis_tvalid && m_axis_tdata[128];
    assign w_miss_clean = (m_axis_tdata[134:129] == 6'd0) && (m_axis_tdata[127:0] == 128'd0);

    `TESP_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !m_axis_tvalid)
    `TESP_ASSERT(a_out_hold, i_clk, i_rst_n, w_stall |=> m_axis_tvalid && $stable(m_axis_tdata))
    `TESP_ASSERT(a_one_at_a_time, i_clk, i_rst_n, w_accept |=> !s_axis_tready)
    `TESP_ASSERT(a_miss_has_no_index, i_clk, i_rst_n, w_miss |-> w_miss_clean)

endmodule

bind tlb_entry_store_and_probe tesp_checker u_tesp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: verif/tb_tlb_entry_store_and_probe.sv
// Self-checking testbench for the translation table with read, write and probe requests.
module tb_tlb_entry_store_and_probe;

    localparam int unsigned ENTRIES         = 64;
    localparam int unsigned RANDOM_REQUESTS = 1630;
    localparam int unsigned CYCLE_LIMIT     = 750000;

    typedef struct packed {
        logic [tesp_pkg::WORD_W-1:0] entry_lo1;
        logic [tesp_pkg::WORD_W-1:0] entry_lo0;
        logic [tesp_pkg::WORD_W-1:0] entry_hi;
        logic [tesp_pkg::WORD_W-1:0] page_mask;
        logic [tesp_pkg::IDX_W-1:0]  random_reg;
        logic [tesp_pkg::IDX_W-1:0]  index_reg;
        tesp_pkg::t_mode             mode;
    } t_request;

    typedef struct packed {
        logic [tesp_pkg::IDX_W-1:0]  probe_index;
        logic                        probe_miss;
        logic [tesp_pkg::WORD_W-1:0] read_entry_lo1;
        logic [tesp_pkg::WORD_W-1:0] read_entry_lo0;
        logic [tesp_pkg::WORD_W-1:0] read_entry_hi;
        logic [tesp_pkg::WORD_W-1:0] read_page_mask;
    } t_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // mode, index_reg, random_reg, page_mask, entry_hi, entry_lo0, entry_lo1, zero fill
    logic [143:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // read_page_mask, read_entry_hi, read_entry_lo0, read_entry_lo1, probe_miss,
    // probe_index, zero fill
    logic [135:0] m_axis_tdata;

    logic [tesp_pkg::WORD_W-1:0] pm_table  [ENTRIES];
    logic [tesp_pkg::WORD_W-1:0] hi_table  [ENTRIES];
    logic [tesp_pkg::WORD_W-1:0] lo0_table [ENTRIES];
    logic [tesp_pkg::WORD_W-1:0] lo1_table [ENTRIES];

    logic [tesp_pkg::WORD_W-1:0] vpn_pool  [4];
    logic [tesp_pkg::ASID_W-1:0] asid_pool [4];

    t_result     pending_results[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned result_stall = 0;
    int unsigned stall_draw;
    bit          no_idle = 1'b0;
    t_result     want;
    t_result     got;

    tlb_entry_store_and_probe #(
        .ENTRIES(ENTRIES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_result apply_tlb_request(input t_request r);
        t_result                     res;
        logic [tesp_pkg::IDX_W-1:0]  slot;
        logic [tesp_pkg::WORD_W-1:0] vmask;
        logic                        g;
        res = '0;
        case (r.mode)
            tesp_pkg::MODE_READ: begin
                slot = r.index_reg;
                g = lo0_table[slot][0] & lo1_table[slot][0];
                res.read_page_mask = pm_table[slot];
                res.read_entry_hi  = hi_table[slot];
                res.read_entry_lo0 = {lo0_table[slot][tesp_pkg::WORD_W-1:1], g};
                res.read_entry_lo1 = {lo1_table[slot][tesp_pkg::WORD_W-1:1], g};
            end
            tesp_pkg::MODE_WRITE_IDX, tesp_pkg::MODE_WRITE_RAND: begin
                slot = (r.mode == tesp_pkg::MODE_WRITE_IDX) ? r.index_reg : r.random_reg;
                g = r.entry_lo0[0] & r.entry_lo1[0];
                pm_table[slot]  = r.page_mask;
                hi_table[slot]  = r.entry_hi & ~(r.page_mask & tesp_pkg::MASK_CLEAR_BITS);
                lo0_table[slot] = {r.entry_lo0[tesp_pkg::WORD_W-1:1], g};
                lo1_table[slot] = {r.entry_lo1[tesp_pkg::WORD_W-1:1], g};
            end
            default: begin
                res.probe_miss = 1'b1;
                for (int i = 0; i < ENTRIES; i++) begin
                    vmask = ~(pm_table[i] | tesp_pkg::LOW_PAGE_BITS);
                    if (((r.entry_hi & vmask) == (hi_table[i] & vmask)) &&
                        ((lo0_table[i][0] & lo1_table[i][0]) ||
                         (hi_table[i][tesp_pkg::ASID_W-1:0] ==
                          r.entry_hi[tesp_pkg::ASID_W-1:0]))) begin
                        res.probe_miss  = 1'b0;
                        res.probe_index = i[tesp_pkg::IDX_W-1:0];
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic t_request tlb_request(input tesp_pkg::t_mode mode,
                                             input logic [tesp_pkg::IDX_W-1:0] idx,
                                             input logic [tesp_pkg::IDX_W-1:0] rnd,
                                             input logic [tesp_pkg::WORD_W-1:0] pm,
                                             input logic [tesp_pkg::WORD_W-1:0] hi,
                                             input logic [tesp_pkg::WORD_W-1:0] lo0,
                                             input logic [tesp_pkg::WORD_W-1:0] lo1);
        t_request r;
        r.mode       = mode;
        r.index_reg  = idx;
        r.random_reg = rnd;
        r.page_mask  = pm;
        r.entry_hi   = hi;
        r.entry_lo0  = lo0;
        r.entry_lo1  = lo1;
        return r;
    endfunction

    function automatic t_request random_request();
        t_request    r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            r.mode = tesp_pkg::MODE_READ;
        end else if (pick < 50) begin
            r.mode = tesp_pkg::MODE_WRITE_IDX;
        end else if (pick < 65) begin
            r.mode = tesp_pkg::MODE_WRITE_RAND;
        end else begin
            r.mode = tesp_pkg::MODE_PROBE;
        end
        r.index_reg  = tesp_pkg::IDX_W'($urandom_range(0, 63));
        r.random_reg = tesp_pkg::IDX_W'($urandom_range(0, 63));
        r.entry_lo0  = $urandom;
        r.entry_lo1  = $urandom;
        if ($urandom_range(0, 6) == 0) begin
            r.mode      = tesp_pkg::t_mode'($urandom_range(0, 3));
            r.page_mask = $urandom;
            r.entry_hi  = $urandom;
        end else begin
            case ($urandom_range(0, 6))
                0: r.page_mask = 32'h0000_0000;
                1: r.page_mask = 32'h0000_6000;
                2: r.page_mask = 32'h0001_e000;
                3: r.page_mask = 32'h0007_e000;
                4: r.page_mask = 32'h01ff_e000;
                5: r.page_mask = 32'h1fff_e000;
                default: r.page_mask = $urandom;
            endcase
            r.entry_hi = vpn_pool[$urandom_range(0, 3)] |
                         {24'h0, asid_pool[$urandom_range(0, 3)]};
            r.entry_hi[12:8] = 5'($urandom);
        end
        return r;
    endfunction

    task automatic send_request(input t_request r);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, r};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(apply_tlb_request(r));
    endtask

    task automatic check_field(input string field,
                               input logic [tesp_pkg::WORD_W-1:0] exp_val,
                               input logic [tesp_pkg::WORD_W-1:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %h, actual %h", field, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            result_stall  <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            stall_draw = no_idle ? 0 : $urandom_range(0, 9);
            result_stall  <= stall_draw;
            m_axis_tready <= (stall_draw == 0);
        end else if (result_stall != 0) begin
            result_stall  <= result_stall - 1;
            m_axis_tready <= (result_stall == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: actual %h", m_axis_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                got  = m_axis_tdata[134:0];
                check_field("read_page_mask", want.read_page_mask, got.read_page_mask);
                check_field("read_entry_hi", want.read_entry_hi, got.read_entry_hi);
                check_field("read_entry_lo0", want.read_entry_lo0, got.read_entry_lo0);
                check_field("read_entry_lo1", want.read_entry_lo1, got.read_entry_lo1);
                check_field("probe_miss", {31'h0, want.probe_miss}, {31'h0, got.probe_miss});
                check_field("probe_index", {26'h0, want.probe_index},
                            {26'h0, got.probe_index});
            end
        end
    end

    task automatic test_reset_contents();
        send_request(tlb_request(tesp_pkg::MODE_READ, 6'd0, 6'd0, '0, '0, '0, '0));
        send_request(tlb_request(tesp_pkg::MODE_READ, 6'd63, 6'd0, '0, '0, '0, '0));
        send_request(tlb_request(tesp_pkg::MODE_PROBE, 6'd0, 6'd0, '0, 32'h0000_0000,
                                 '0, '0));
        send_request(tlb_request(tesp_pkg::MODE_PROBE, 6'd0, 6'd0, '0, 32'h0000_0001,
                                 '0, '0));
    endtask

    task automatic test_write_read_extremes();
        send_request(tlb_request(tesp_pkg::MODE_WRITE_IDX, 6'd0, 6'd63, '1, '1, '1, '1));
        send_request(tlb_request(tesp_pkg::MODE_READ, 6'd0, 6'd63, '0, '0, '0, '0));
        send_request(tlb_request(tesp_pkg::MODE_WRITE_RAND, 6'd0, 6'd63, 32'h0, 32'h0,
                                 32'hffff_ffff, 32'hffff_fffe));
        send_request(tlb_request(tesp_pkg::MODE_READ, 6'd63, 6'd0, '0, '0, '0, '0));
        send_request(tlb_request(tesp_pkg::MODE_READ, 6'd0, 6'd0, '0, '0, '0, '0));
        send_request(tlb_request(tesp_pkg::MODE_WRITE_IDX, 6'd5, 6'd0, 32'h0001_e000,
                                 32'h1234_5678, 32'h0000_0000, 32'h0000_0001));
        send_request(tlb_request(tesp_pkg::MODE_READ, 6'd5, 6'd0, '0, '0, '0, '0));
        send_request(tlb_request(tesp_pkg::MODE_WRITE_RAND, 6'd33, 6'd0, '0, '0, '0, '0));
        send_request(tlb_request(tesp_pkg::MODE_READ, 6'd0, 6'd33, '0, '0, '0, '0));
    endtask

    task automatic test_probe_cases();
        // A private entry at index zero must be reported as a hit.
        send_request(tlb_request(tesp_pkg::MODE_WRITE_IDX, 6'd0, 6'd0, 32'h0, 32'h8000_0042,
                                 32'h1, 32'h0));
        send_request(tlb_request(tesp_pkg::MODE_WRITE_IDX, 6'd63, 6'd0, 32'h0, 32'h4000_0011,
                                 32'h1, 32'h1));
        send_request(tlb_request(tesp_pkg::MODE_PROBE, 6'd0, 6'd0, '0, 32'h8000_0042,
                                 '0, '0));
        send_request(tlb_request(tesp_pkg::MODE_PROBE, 6'd0, 6'd0, '0, 32'h8000_0043,
                                 '0, '0));
        send_request(tlb_request(tesp_pkg::MODE_PROBE, 6'd0, 6'd0, '0, 32'h4000_00ff,
                                 '0, '0));
        // Two entries cover the same large page, so the higher index must win.
        send_request(tlb_request(tesp_pkg::MODE_WRITE_IDX, 6'd10, 6'd0, 32'h01ff_e000,
                                 32'h3abc_d0aa, 32'h0, 32'h0));
        send_request(tlb_request(tesp_pkg::MODE_PROBE, 6'd0, 6'd0, '0, 32'h3a12_34aa,
                                 '0, '0));
        send_request(tlb_request(tesp_pkg::MODE_WRITE_IDX, 6'd20, 6'd0, 32'h01ff_e000,
                                 32'h3abc_d0aa, 32'h0, 32'h0));
        send_request(tlb_request(tesp_pkg::MODE_PROBE, 6'd0, 6'd0, '0, 32'h3a12_34aa,
                                 '0, '0));
    endtask

    task automatic test_random_traffic();
        for (int k = 0; k < 4; k++) begin
            vpn_pool[k]  = $urandom & ~tesp_pkg::LOW_PAGE_BITS;
            asid_pool[k] = tesp_pkg::ASID_W'($urandom);
        end
        vpn_pool[1] = vpn_pool[0] ^ 32'h0000_2000;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 60 == 0) begin
                no_idle = ($urandom_range(0, 4) == 0);
            end
            send_request(random_request());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            pm_table[i]  = '0;
            hi_table[i]  = '0;
            lo0_table[i] = '0;
            lo1_table[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_contents();
        test_write_read_extremes();
        test_probe_cases();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (ENTRIES + 8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
